>>> hdl/lz78_pkg.sv
// Shared constants and controller/datapath interface types for the LZ78 encoder.
`default_nettype none
package lz78_pkg;
  localparam int unsigned DICT_ENTRIES_DEF = 4096;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CMP_W    = IDX_W + 1;
  localparam logic [IDX_W-1:0] LIMIT_RST = 12'hFFF;

  // controller -> datapath
  typedef struct packed {
    logic start;   // capture input item, restart scan at index 1
    logic rd;      // read dictionary entry at scan index
    logic inc;     // advance scan index
    logic hit;     // record current scan index as match
    logic finish;  // update dictionary/state, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;  // scan index reached next free index
    logic match;     // registered entry equals search key
    logic out_free;  // result register can take a new item
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/lz78_ctrl.sv
// Sequencer for the LZ78 encoder: accept, dictionary scan, finish.
`default_nettype none
module lz78_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  lz78_pkg::sts_t   sts_i,
  output lz78_pkg::cmd_t   cmd_o
);
  typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_FIN} state_e;
  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.start = in_valid_i;
      S_RD:   cmd_o.rd    = !sts_i.scan_end;
      S_CMP: begin
        cmd_o.hit = sts_i.match;
        cmd_o.inc = !sts_i.match;
      end
      S_FIN:  cmd_o.finish = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_RD;
        S_RD:   state_q <= sts_i.scan_end ? S_FIN : S_CMP;
        S_CMP:  state_q <= sts_i.match ? S_FIN : S_RD;
        S_FIN:  if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/lz78_dpath.sv
// Datapath for the LZ78 encoder: phrase memory, scan counter, result register.
`default_nettype none
module lz78_dpath #(
  parameter int unsigned DICT_ENTRIES = lz78_pkg::DICT_ENTRIES_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [lz78_pkg::IDX_W-1:0]      cfg_data_i,
  input  wire  [lz78_pkg::BYTE_W-1:0]     in_byte_i,
  input  wire                             last_byte_i,
  input  lz78_pkg::cmd_t                  cmd_i,
  output lz78_pkg::sts_t                  sts_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [lz78_pkg::IDX_W-1:0]      code_index_o,
  output logic [lz78_pkg::BYTE_W-1:0]     code_byte_o,
  output logic                            has_byte_o,
  output logic                            end_of_stream_o,
  output logic                            dict_full_o
);
  // indices never exceed 4095, so depth is capped there
  localparam int unsigned DEPTH = (DICT_ENTRIES > 4096) ? 4096 : DICT_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = lz78_pkg::BYTE_W;
  localparam int unsigned CW    = lz78_pkg::CMP_W;

  logic [AW+BW-1:0] mem [DEPTH];
  logic [AW+BW-1:0] rd_q;

  logic [lz78_pkg::IDX_W-1:0] limit_q;
  logic [AW:0]    nfi_q, nfi_d;
  logic [AW:0]    k_q;
  logic [AW-1:0]  node_q, node_d;
  logic [AW-1:0]  hit_idx_q;
  logic           hit_q;
  logic [BW-1:0]  byte_q;
  logic           last_q;

  logic [lz78_pkg::IDX_W-1:0] lim;
  logic full_pre, full_post, do_ins, emit;
  logic [lz78_pkg::IDX_W-1:0] res_idx;
  logic [BW-1:0] res_byte;

  always_comb begin
    lim = (limit_q > lz78_pkg::IDX_W'(DEPTH - 1)) ? lz78_pkg::IDX_W'(DEPTH - 1) : limit_q;
    full_pre  = CW'(nfi_q) > CW'(lim);
    do_ins    = !hit_q && !full_pre && (CW'(nfi_q) < CW'(DEPTH));
    nfi_d     = do_ins ? nfi_q + 1'b1 : nfi_q;
    full_post = CW'(nfi_d) > CW'(lim);
    emit      = hit_q ? last_q : 1'b1;
    res_idx   = hit_q ? lz78_pkg::IDX_W'(hit_idx_q) : lz78_pkg::IDX_W'(node_q);
    res_byte  = hit_q ? '0 : byte_q;
    node_d    = (hit_q && !last_q) ? hit_idx_q : '0;
  end

  assign sts_o.scan_end = (k_q >= nfi_q);
  assign sts_o.match    = (rd_q == {node_q, byte_q});
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[k_q[AW-1:0]];
    if (cmd_i.finish && do_ins) mem[nfi_q[AW-1:0]] <= {node_q, byte_q};
    if (cmd_i.start) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end
    if (cmd_i.hit) hit_idx_q <= k_q[AW-1:0];
    if (cmd_i.finish && emit) begin
      code_index_o    <= res_idx;
      code_byte_o     <= res_byte;
      has_byte_o      <= !hit_q;
      end_of_stream_o <= last_q;
      dict_full_o     <= full_post;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= lz78_pkg::LIMIT_RST;
      nfi_q       <= (AW+1)'(1);
      k_q         <= (AW+1)'(1);
      node_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (cmd_i.start) begin
        k_q   <= (AW+1)'(1);
        hit_q <= 1'b0;
      end else if (cmd_i.inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.hit) hit_q <= 1'b1;
      // a new code replaces one taken in the same cycle
      if (cmd_i.finish && emit) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cmd_i.finish) begin
        node_q <= node_d;
        nfi_q  <= last_q ? (AW+1)'(1) : nfi_d;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/lz78_encoder.sv
// Top level of the LZ78 encoder: controller plus datapath.
//
// Input channel: in_valid_i / in_stall_o carry one byte item (in_byte_i,
// last_byte_i). An item is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry one code item per unmatched
// byte, and one for a matched last byte (has_byte_o = 0).
// Config: cfg_we_i writes dict_limit from cfg_data_i; the user must write it
// only while idle, which the block itself does not enforce.
// Each byte searches the phrase memory linearly, one entry read (S_RD) and
// then one compare (S_CMP) per entry, over indices 1 .. next_free-1 of the
// current stream, so over at most 4095 entries. The single memory port and
// the scan loop set how long the search of a byte runs; the search grows
// with the number of entries searched.
// The next item is taken while a finished code still waits in the output
// register; a stalled receiver holds the finish step of any item, code or
// not, while the output register is still full.
// Reset clears the controller, the current node (root), the fill count
// (next free index 1) and sets dict_limit to 4095. The phrase memory is not
// cleared: only entries below the fill count are ever read. After a last
// byte the fill count and node return to their reset values.
`default_nettype none
module lz78_encoder #(
  parameter int unsigned DICT_ENTRIES = lz78_pkg::DICT_ENTRIES_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [lz78_pkg::IDX_W-1:0]   cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [lz78_pkg::BYTE_W-1:0]  in_byte_i,
  input  wire                          last_byte_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [lz78_pkg::IDX_W-1:0]   code_index_o,
  output logic [lz78_pkg::BYTE_W-1:0]  code_byte_o,
  output logic                         has_byte_o,
  output logic                         end_of_stream_o,
  output logic                         dict_full_o
);
  lz78_pkg::cmd_t cmd;
  lz78_pkg::sts_t sts;

  lz78_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lz78_dpath #(.DICT_ENTRIES(DICT_ENTRIES)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_byte_i       (in_byte_i),
    .last_byte_i     (last_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_index_o    (code_index_o),
    .code_byte_o     (code_byte_o),
    .has_byte_o      (has_byte_o),
    .end_of_stream_o (end_of_stream_o),
    .dict_full_o     (dict_full_o)
  );

  // an accepted item always blocks the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("accept not followed by busy");

  // a byteless code only closes a stream
  a_flush_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> end_of_stream_o) else $error("flush without end");

  a_flush_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> code_byte_o == '0) else $error("flush byte not zero");
endmodule
`default_nettype wire
